// ----- rtl/twsc_pkg.sv -----
// Package for the two-wire sound command sender.
// Holds the word types, command and register index codes, and timing constants.
// No dependencies.
package twsc_pkg;

  localparam int WORD_BITS = 16;
  localparam int BITS_W    = $clog2(WORD_BITS + 1);
  localparam int TICK_W    = 12;
  localparam int SHORT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = TICK_W;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // request codes carried in cmd
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_SEND      = 2'd1;
  localparam logic [1:0] CMD_SEND_WAIT = 2'd2;
  localparam logic [1:0] CMD_RESET     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SETUP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DATA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_GAP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_PULSE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SETTLE = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] command_word;
    logic        busy_in;
  } in_word_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic reset_line;
    logic idle;
    logic accepted;
  } out_word_t;

  typedef struct packed {
    logic [TICK_W-1:0]  start_hold_ticks;
    logic [SHORT_W-1:0] bit_setup_ticks;
    logic [SHORT_W-1:0] bit_data_ticks;
    logic [SHORT_W-1:0] bit_high_ticks;
    logic [TICK_W-1:0]  end_gap_ticks;
    logic [TICK_W-1:0]  reset_pulse_ticks;
    logic [TICK_W-1:0]  reset_settle_ticks;
  } cfg_t;

endpackage

// ----- rtl/twsc_cfg.sv -----
// Timing configuration registers of the two-wire sound command sender.
// Depends on twsc_pkg.
module twsc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [twsc_pkg::CFG_IDX_W-1:0] wr_idx,
  input  logic [twsc_pkg::CFG_DAT_W-1:0] wr_data,
  output twsc_pkg::cfg_t                 cfg
);

  twsc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_hold_ticks   <= 12'd20;
      cfg_r.bit_setup_ticks    <= 4'd1;
      cfg_r.bit_data_ticks     <= 4'd1;
      cfg_r.bit_high_ticks     <= 4'd2;
      cfg_r.end_gap_ticks      <= 12'd200;
      cfg_r.reset_pulse_ticks  <= 12'd50;
      cfg_r.reset_settle_ticks <= 12'd3000;
    end else if (wr_en) begin
      case (wr_idx)
        twsc_pkg::REG_START_HOLD:   cfg_r.start_hold_ticks   <= wr_data;
        twsc_pkg::REG_BIT_SETUP:    cfg_r.bit_setup_ticks    <= wr_data[twsc_pkg::SHORT_W-1:0];
        twsc_pkg::REG_BIT_DATA:     cfg_r.bit_data_ticks     <= wr_data[twsc_pkg::SHORT_W-1:0];
        twsc_pkg::REG_BIT_HIGH:     cfg_r.bit_high_ticks     <= wr_data[twsc_pkg::SHORT_W-1:0];
        twsc_pkg::REG_END_GAP:      cfg_r.end_gap_ticks      <= wr_data;
        twsc_pkg::REG_RESET_PULSE:  cfg_r.reset_pulse_ticks  <= wr_data;
        twsc_pkg::REG_RESET_SETTLE: cfg_r.reset_settle_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/twsc_core.sv -----
// Line sequencer: phase, tick counter, bit counter and shift register.
// Advances once per word; gives the next line levels for the result register.
// Depends on twsc_pkg.
module twsc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  twsc_pkg::in_word_t  in_word,
  input  twsc_pkg::cfg_t      cfg,
  output twsc_pkg::out_word_t res_nxt
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_SETUP    = 4'd2,
    PH_DATA     = 4'd3,
    PH_HIGH     = 4'd4,
    PH_GAP      = 4'd5,
    PH_WAITBUSY = 4'd6,
    PH_RPULSE   = 4'd7,
    PH_RSETTLE  = 4'd8
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [twsc_pkg::TICK_W-1:0]        tick_r, tick_nxt, tick_inc;
  logic [twsc_pkg::BITS_W-1:0]        bits_r, bits_nxt, bits_dec;
  logic [twsc_pkg::WORD_BITS-1:0]     shift_r, shift_nxt;
  logic                               clk_lvl_r, clk_lvl_nxt;
  logic                               dat_lvl_r, dat_lvl_nxt;
  logic                               rst_lvl_r, rst_lvl_nxt;
  logic                               wait_r, wait_nxt;
  logic                               acc;
  logic [twsc_pkg::TICK_W-1:0]        len;

  always_comb begin
    case (phase_r)
      PH_START:   len = cfg.start_hold_ticks;
      PH_SETUP:   len = {{(twsc_pkg::TICK_W-twsc_pkg::SHORT_W){1'b0}}, cfg.bit_setup_ticks};
      PH_DATA:    len = {{(twsc_pkg::TICK_W-twsc_pkg::SHORT_W){1'b0}}, cfg.bit_data_ticks};
      PH_HIGH:    len = {{(twsc_pkg::TICK_W-twsc_pkg::SHORT_W){1'b0}}, cfg.bit_high_ticks};
      PH_GAP:     len = cfg.end_gap_ticks;
      PH_RPULSE:  len = cfg.reset_pulse_ticks;
      PH_RSETTLE: len = cfg.reset_settle_ticks;
      default:    len = {{(twsc_pkg::TICK_W-1){1'b0}}, 1'b1};
    endcase
  end

  assign tick_inc = (tick_r == twsc_pkg::TICK_MAX) ? tick_r : tick_r + 1'b1;
  assign bits_dec = (bits_r != '0) ? bits_r - 1'b1 : bits_r;

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bits_nxt    = bits_r;
    shift_nxt   = shift_r;
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    rst_lvl_nxt = rst_lvl_r;
    wait_nxt    = wait_r;
    acc         = 1'b0;
    if (in_word.cmd != twsc_pkg::CMD_TICK && phase_r == PH_IDLE) begin
      acc      = 1'b1;
      tick_nxt = '0;
      if (in_word.cmd == twsc_pkg::CMD_RESET) begin
        phase_nxt   = PH_RPULSE;
        clk_lvl_nxt = 1'b0;
        rst_lvl_nxt = 1'b0;
      end else begin
        phase_nxt   = PH_START;
        clk_lvl_nxt = 1'b0;
        shift_nxt   = in_word.command_word[twsc_pkg::WORD_BITS-1:0];
        bits_nxt    = twsc_pkg::BITS_W'(twsc_pkg::WORD_BITS);
        wait_nxt    = (in_word.cmd == twsc_pkg::CMD_SEND_WAIT);
      end
    end else begin
      case (phase_r)
        PH_IDLE: ;
        PH_WAITBUSY: begin
          if (!in_word.busy_in) begin
            phase_nxt = PH_IDLE;
            wait_nxt  = 1'b0;
          end
        end
        PH_START, PH_SETUP, PH_DATA, PH_HIGH, PH_GAP, PH_RPULSE, PH_RSETTLE: begin
          tick_nxt = tick_inc;
          if (tick_inc >= len) begin
            tick_nxt = '0;
            case (phase_r)
              PH_START: begin
                phase_nxt   = PH_SETUP;
                clk_lvl_nxt = 1'b0;
              end
              PH_SETUP: begin
                // present the MSB and shift it out
                phase_nxt   = PH_DATA;
                dat_lvl_nxt = shift_r[twsc_pkg::WORD_BITS-1];
                shift_nxt   = shift_r << 1;
              end
              PH_DATA: begin
                phase_nxt   = PH_HIGH;
                clk_lvl_nxt = 1'b1;
              end
              PH_HIGH: begin
                bits_nxt = bits_dec;
                if (bits_dec != '0) begin
                  phase_nxt   = PH_SETUP;
                  clk_lvl_nxt = 1'b0;
                end else begin
                  phase_nxt   = PH_GAP;
                  clk_lvl_nxt = 1'b1;
                  dat_lvl_nxt = 1'b1;
                end
              end
              PH_GAP: begin
                if (wait_r && in_word.busy_in) begin
                  phase_nxt = PH_WAITBUSY;
                end else begin
                  phase_nxt = PH_IDLE;
                  wait_nxt  = 1'b0;
                end
              end
              PH_RPULSE: begin
                phase_nxt   = PH_RSETTLE;
                clk_lvl_nxt = 1'b1;
                rst_lvl_nxt = 1'b1;
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bits_r    <= '0;
      shift_r   <= '0;
      clk_lvl_r <= 1'b1;
      dat_lvl_r <= 1'b1;
      rst_lvl_r <= 1'b1;
      wait_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bits_r    <= bits_nxt;
      shift_r   <= shift_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dat_lvl_r <= dat_lvl_nxt;
      rst_lvl_r <= rst_lvl_nxt;
      wait_r    <= wait_nxt;
    end
  end

  assign res_nxt.clock_line = clk_lvl_nxt;
  assign res_nxt.data_line  = dat_lvl_nxt;
  assign res_nxt.reset_line = rst_lvl_nxt;
  assign res_nxt.idle       = (phase_nxt == PH_IDLE);
  assign res_nxt.accepted   = acc;

endmodule

// ----- rtl/two_wire_sound_command_sender.sv -----
// Two-wire sound command sender, top level.
// Throughput: one word per cycle while out_stall is low; input register, sequencer step, result register.
// Config writes are always ready.
// Reset (rst_n low, synchronous): lines high, idle, both word registers empty,
// timing registers back to their defaults.
module two_wire_sound_command_sender (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  twsc_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output twsc_pkg::out_word_t            out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [twsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twsc_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  twsc_pkg::in_word_t  in_word_r;
  twsc_pkg::out_word_t out_word_r;
  twsc_pkg::out_word_t res_nxt;
  twsc_pkg::cfg_t      cfg;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;

  // held word moves to the result register when that one is free or being taken
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  twsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_wdata),
    .cfg     (cfg)
  );

  twsc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_word (in_word_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- tb/two_wire_sound_command_sender_tb.sv -----
// Self-checking testbench for the two-wire sound command sender.
// Drives tick/request words, predicts results (sequencer model or typed row),
// compares field by field. Depends on twsc_pkg and the RTL top level.
`timescale 1ns / 1ps

module two_wire_sound_command_sender_tb;
  import twsc_pkg::*;

  localparam int RUN_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // result words that can be read straight off the spec
  localparam out_word_t LINES_QUIET   = 5'b11110;
  localparam out_word_t SEND_TAKEN    = 5'b01101;
  localparam out_word_t START_REFUSED = 5'b01100;
  localparam out_word_t RESET_TAKEN   = 5'b01001;
  localparam out_word_t PULSE_REFUSED = 5'b01000;
  localparam out_word_t NO_WANT       = 5'b00000;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_SETUP, SEQ_DATA, SEQ_HIGH, SEQ_GAP,
    SEQ_WAIT_BUSY, SEQ_RST_PULSE, SEQ_RST_SETTLE
  } seq_phase_e;

  typedef enum int { PACE_RCV_LAGS, PACE_SND_LAGS, PACE_FULL } pace_e;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] word;
    logic        busy;
    int          reps;
    bit          until_idle;
    bit          fast_cfg;
    bit          typed;
    out_word_t   want;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  // sequencer model state
  seq_phase_e           sq_phase;
  logic [TICK_W-1:0]    sq_count;
  logic [BITS_W-1:0]    sq_bits_left;
  logic [WORD_BITS-1:0] sq_shift;
  logic                 sq_clk, sq_data, sq_rst, sq_hold_busy;
  cfg_t                 sq_cfg;

  out_word_t exp_q [$];
  bit        row_typed;
  out_word_t row_exp;

  int snd_gap_pct, rcv_stall_pct;
  int hold_asks, hold_done;
  int n_errors, n_items, n_checked, n_sends, n_resets, n_settings, cycle_cnt;

  two_wire_sound_command_sender i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  step_row_t steps [22] = '{
    '{CMD_TICK,      16'h0000, 1'b0,  1, 1'b0, 1'b0, 1'b1, LINES_QUIET},
    '{CMD_SEND,      16'hFFFF, 1'b1,  1, 1'b0, 1'b0, 1'b1, SEND_TAKEN},
    '{CMD_RESET,     16'h0000, 1'b0,  1, 1'b0, 1'b0, 1'b1, START_REFUSED},
    '{CMD_SEND_WAIT, 16'h5555, 1'b1,  1, 1'b0, 1'b0, 1'b1, START_REFUSED},
    '{CMD_SEND,      16'h0001, 1'b0,  1, 1'b0, 1'b0, 1'b1, START_REFUSED},
    '{CMD_TICK,      16'h0000, 1'b0,  0, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{CMD_RESET,     16'h0000, 1'b0,  1, 1'b0, 1'b0, 1'b1, RESET_TAKEN},
    '{CMD_SEND_WAIT, 16'hFFFF, 1'b0,  1, 1'b0, 1'b0, 1'b1, PULSE_REFUSED},
    '{CMD_TICK,      16'h0000, 1'b0,  0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{CMD_SEND,      16'h0000, 1'b0,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_TICK,      16'h0000, 1'b1,  0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{CMD_SEND_WAIT, 16'h8000, 1'b1,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    // long enough to run through the end gap into the wait on busy
    '{CMD_TICK,      16'hFFFF, 1'b1, 80, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_SEND,      16'hFFFF, 1'b1,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_TICK,      16'h0000, 1'b0,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_SEND_WAIT, 16'hAAAA, 1'b0,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_TICK,      16'h0000, 1'b0,  0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{CMD_SEND,      16'h7FFF, 1'b1,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_TICK,      16'h0000, 1'b1,  0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{CMD_RESET,     16'h0000, 1'b1,  1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{CMD_TICK,      16'h0000, 1'b0,  0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{CMD_SEND_WAIT, 16'h0001, 1'b0,  1, 1'b0, 1'b0, 1'b0, NO_WANT}
  };

  function automatic cfg_t make_cfg(input logic [11:0] hold, input logic [3:0] setup,
                                    input logic [3:0] dat, input logic [3:0] hi,
                                    input logic [11:0] gap, input logic [11:0] pulse,
                                    input logic [11:0] settle);
    cfg_t c;
    c.start_hold_ticks   = hold;
    c.bit_setup_ticks    = setup;
    c.bit_data_ticks     = dat;
    c.bit_high_ticks     = hi;
    c.end_gap_ticks      = gap;
    c.reset_pulse_ticks  = pulse;
    c.reset_settle_ticks = settle;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    return make_cfg(12'($urandom_range(1, 8)), 4'($urandom_range(1, 3)),
                    4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)),
                    12'($urandom_range(1, 8)), 12'($urandom_range(1, 6)),
                    12'($urandom_range(1, 10)));
  endfunction

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_START_HOLD:   sq_cfg.start_hold_ticks   = d;
      REG_BIT_SETUP:    sq_cfg.bit_setup_ticks    = d[SHORT_W-1:0];
      REG_BIT_DATA:     sq_cfg.bit_data_ticks     = d[SHORT_W-1:0];
      REG_BIT_HIGH:     sq_cfg.bit_high_ticks     = d[SHORT_W-1:0];
      REG_END_GAP:      sq_cfg.end_gap_ticks      = d;
      REG_RESET_PULSE:  sq_cfg.reset_pulse_ticks  = d;
      REG_RESET_SETTLE: sq_cfg.reset_settle_ticks = d;
      default: ;
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] phase_len();
    case (sq_phase)
      SEQ_START:      return sq_cfg.start_hold_ticks;
      SEQ_SETUP:      return {8'd0, sq_cfg.bit_setup_ticks};
      SEQ_DATA:       return {8'd0, sq_cfg.bit_data_ticks};
      SEQ_HIGH:       return {8'd0, sq_cfg.bit_high_ticks};
      SEQ_GAP:        return sq_cfg.end_gap_ticks;
      SEQ_RST_PULSE:  return sq_cfg.reset_pulse_ticks;
      SEQ_RST_SETTLE: return sq_cfg.reset_settle_ticks;
      default:        return 12'd1;
    endcase
  endfunction

  function automatic void enter_phase(input seq_phase_e p);
    sq_phase = p;
    sq_count = '0;
    case (p)
      SEQ_START, SEQ_SETUP: sq_clk = 1'b0;
      SEQ_DATA: begin
        sq_data  = sq_shift[WORD_BITS-1];
        sq_shift = sq_shift << 1;
      end
      SEQ_HIGH: sq_clk = 1'b1;
      SEQ_GAP: begin
        sq_clk  = 1'b1;
        sq_data = 1'b1;
      end
      SEQ_RST_PULSE: begin
        sq_clk = 1'b0;
        sq_rst = 1'b0;
      end
      SEQ_RST_SETTLE: begin
        sq_clk = 1'b1;
        sq_rst = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void advance_tick(input logic busy);
    if (sq_phase == SEQ_IDLE) return;
    if (sq_phase == SEQ_WAIT_BUSY) begin
      if (!busy) begin
        sq_phase     = SEQ_IDLE;
        sq_hold_busy = 1'b0;
      end
      return;
    end
    if (sq_count != TICK_MAX) sq_count++;
    // a zero length still needs one tick, so the compare covers it
    if (sq_count < phase_len()) return;
    case (sq_phase)
      SEQ_START: enter_phase(SEQ_SETUP);
      SEQ_SETUP: enter_phase(SEQ_DATA);
      SEQ_DATA:  enter_phase(SEQ_HIGH);
      SEQ_HIGH: begin
        if (sq_bits_left != 0) sq_bits_left--;
        if (sq_bits_left != 0) enter_phase(SEQ_SETUP);
        else enter_phase(SEQ_GAP);
      end
      SEQ_GAP: begin
        sq_count = '0;
        if (sq_hold_busy && busy) begin
          sq_phase = SEQ_WAIT_BUSY;
        end else begin
          sq_phase     = SEQ_IDLE;
          sq_hold_busy = 1'b0;
        end
      end
      SEQ_RST_PULSE: enter_phase(SEQ_RST_SETTLE);
      default: begin
        sq_phase = SEQ_IDLE;
        sq_count = '0;
      end
    endcase
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    r.accepted = 1'b0;
    if (w.cmd != CMD_TICK && sq_phase == SEQ_IDLE) begin
      r.accepted = 1'b1;
      if (w.cmd == CMD_RESET) begin
        enter_phase(SEQ_RST_PULSE);
        n_resets++;
      end else begin
        sq_shift     = w.command_word[WORD_BITS-1:0];
        sq_bits_left = BITS_W'(WORD_BITS);
        sq_hold_busy = (w.cmd == CMD_SEND_WAIT);
        enter_phase(SEQ_START);
        n_sends++;
      end
    end else begin
      advance_tick(w.busy_in);
    end
    r.clock_line = sq_clk;
    r.data_line  = sq_data;
    r.reset_line = sq_rst;
    r.idle       = (sq_phase == SEQ_IDLE);
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h0001;
      4:       return 16'h7FFF;
      5:       return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly real requests when idle, mostly ticks with a little noise while busy
  function automatic in_word_t pick_item();
    in_word_t w;
    int r;
    r = $urandom_range(99);
    w.command_word = pick_word();
    w.busy_in = 1'($urandom_range(1));
    if (sq_phase == SEQ_IDLE) begin
      if (r < 42) w.cmd = CMD_SEND;
      else if (r < 78) w.cmd = CMD_SEND_WAIT;
      else if (r < 90) w.cmd = CMD_RESET;
      else w.cmd = CMD_TICK;
    end else begin
      w.cmd = (r < 8) ? 2'($urandom_range(3)) : CMD_TICK;
      if (sq_phase == SEQ_WAIT_BUSY) w.busy_in = ($urandom_range(99) < 75);
    end
    return w;
  endfunction

  function automatic void set_pace(input pace_e p);
    case (p)
      PACE_RCV_LAGS: begin snd_gap_pct = 24; rcv_stall_pct = 71; end
      PACE_SND_LAGS: begin snd_gap_pct = 71; rcv_stall_pct = 24; end
      default:       begin snd_gap_pct = 0;  rcv_stall_pct = 0;  end
    endcase
  endfunction

  task automatic note_error(input string msg);
    n_errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      note_error($sformatf("result %0d %s got %b want %b", n_checked, name, got, want));
  endtask

  // caller sits at a falling edge; returns at the edge that takes the word
  task automatic drive(input in_word_t w, input bit typed, input out_word_t want);
    while ($urandom_range(99) < snd_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_word   = w;
    row_typed = typed;
    row_exp   = want;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic ticks_until_idle(input logic busy);
    in_word_t w;
    w.cmd = CMD_TICK;
    w.busy_in = busy;
    forever begin
      @(negedge clk);
      if (sq_phase == SEQ_IDLE) begin
        in_valid = 1'b0;
        break;
      end
      w.command_word = 16'($urandom);
      drive(w, 1'b0, NO_WANT);
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
  endtask

  // all seven registers plus the unused index; junk in the unused upper bits
  task automatic load_regs(input cfg_t c);
    logic [CFG_DAT_W-1:0] vals [8];
    vals[0] = c.start_hold_ticks;
    vals[1] = {8'($urandom), c.bit_setup_ticks};
    vals[2] = {8'($urandom), c.bit_data_ticks};
    vals[3] = {8'($urandom), c.bit_high_ticks};
    vals[4] = c.end_gap_ticks;
    vals[5] = c.reset_pulse_ticks;
    vals[6] = c.reset_settle_ticks;
    vals[7] = 12'($urandom);
    for (int i = 0; i <= int'(REG_NONE); i++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_wdata = vals[i];
      do @(posedge clk); while (!cfg_ready);
      set_reg(cfg_index, cfg_wdata);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input cfg_t c, input int n_words, input pace_e p,
                           input bit squeeze);
    ticks_until_idle(1'b0);
    quiesce();
    set_pace(p);
    load_regs(c);
    if (squeeze) hold_asks++;
    repeat (n_words) begin
      @(negedge clk);
      drive(pick_item(), 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      out_word_t r;
      r = predict_word(in_word);
      exp_q.push_back(row_typed ? row_exp : r);
      n_items++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_word_t e;
      if (exp_q.size() == 0) begin
        note_error($sformatf("result word %b with nothing expected", out_word));
      end else begin
        e = exp_q.pop_front();
        check_field("clock_line", out_word.clock_line, e.clock_line);
        check_field("data_line", out_word.data_line, e.data_line);
        check_field("reset_line", out_word.reset_line, e.reset_line);
        check_field("idle", out_word.idle, e.idle);
        check_field("accepted", out_word.accepted, e.accepted);
      end
      n_checked++;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_done != hold_asks) begin
        hold_left = HOLD_CYCLES;
        hold_done++;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, exp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    step_row_t row;
    in_word_t w;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    row_typed = 1'b0;
    row_exp   = NO_WANT;
    sq_cfg    = make_cfg(12'd20, 4'd1, 4'd1, 4'd2, 12'd200, 12'd50, 12'd3000);
    sq_phase  = SEQ_IDLE;
    sq_count  = '0;
    sq_bits_left = '0;
    sq_shift  = '0;
    sq_clk    = 1'b1;
    sq_data   = 1'b1;
    sq_rst    = 1'b1;
    sq_hold_busy = 1'b0;
    set_pace(PACE_RCV_LAGS);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows; the fast setting lands mid-send and has a zero data length
    foreach (steps[k]) begin
      row = steps[k];
      if (row.fast_cfg) begin
        quiesce();
        load_regs(make_cfg(12'd2, 4'd1, 4'd0, 4'd1, 12'd3, 12'd2, 12'd3));
      end
      w.cmd = row.cmd;
      w.command_word = row.word;
      w.busy_in = row.busy;
      if (row.until_idle) begin
        ticks_until_idle(row.busy);
      end else begin
        repeat (row.reps) begin
          @(negedge clk);
          drive(w, row.typed, row.want);
        end
      end
    end

    run_phase(make_cfg(12'd3, 4'd1, 4'd2, 4'd1, 12'd4, 12'd2, 12'd5), 80,
              PACE_RCV_LAGS, 1'b0);
    run_phase(make_cfg(12'd1, 4'd1, 4'd1, 4'd1, 12'd1, 12'd1, 12'd1), 80,
              PACE_RCV_LAGS, 1'b1);
    run_phase(rand_cfg(), 60, PACE_SND_LAGS, 1'b1);
    run_phase(make_cfg(12'd0, 4'd0, 4'd0, 4'd0, 12'd0, 12'd0, 12'd0), 40,
              PACE_SND_LAGS, 1'b0);
    run_phase(rand_cfg(), 60, PACE_FULL, 1'b0);
    run_phase(make_cfg(12'd4095, 4'd15, 4'd15, 4'd15, 12'd4095, 12'd4095, 12'd4095), 20,
              PACE_FULL, 1'b0);
    // shorten the full-scale phase in progress so it ends in a few ticks
    quiesce();
    load_regs(make_cfg(12'd1, 4'd1, 4'd1, 4'd1, 12'd1, 12'd1, 12'd1));
    ticks_until_idle(1'b0);
    quiesce();
    repeat (8) @(posedge clk);
    if (exp_q.size() != 0) note_error($sformatf("%0d results never came", exp_q.size()));

    $display("%0d words in, %0d results checked, %0d sends and %0d module resets taken",
             n_items, n_checked, n_sends, n_resets);
    $display("%0d register settings incl. zero and full scale, three pacing modes, %0d cycles",
             n_settings, cycle_cnt);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
